// ===== src/dfs_pkg.sv =====
// Package for directional_focus_select: payload structs, widths, opcodes,
// register indexes and the controller state type. No dependencies.
package dfs_pkg;

   localparam int COORD_BITS = 16;
   localparam int ID_BITS    = 16;
   localparam int FRAC_BITS  = 8;
   localparam int SIZE_BITS  = COORD_BITS - 1;
   localparam int DIST_W     = 28;

   // edges (x + w - 1) need two more bits than a coordinate
   localparam int EDGE_W = COORD_BITS + 2;
   localparam int DIFF_W = EDGE_W;
   localparam int SQ_W   = 2 * DIFF_W + 1;
   localparam int RAD_W  = SQ_W + (SQ_W % 2);
   localparam int ROOT_W = RAD_W / 2 + FRAC_BITS;
   localparam int LIN_W  = DIFF_W + 3;
   localparam int SC_W   = ((ROOT_W > LIN_W + FRAC_BITS) ? ROOT_W : LIN_W + FRAC_BITS) + 1;

   localparam logic [DIST_W-1:0] MAX_DIST = DIST_W'(64'd1000000 << FRAC_BITS);

   localparam logic [2:0] OP_UP    = 3'd0;
   localparam logic [2:0] OP_DOWN  = 3'd1;
   localparam logic [2:0] OP_LEFT  = 3'd2;
   localparam logic [2:0] OP_RIGHT = 3'd3;
   localparam logic [2:0] OP_FOCUS = 3'd4;

   localparam int ADDR_W = 4;
   localparam logic [1:0] REG_VIEW_X = 2'd0;
   localparam logic [1:0] REG_VIEW_Y = 2'd1;
   localparam logic [1:0] REG_VIEW_W = 2'd2;
   localparam logic [1:0] REG_VIEW_H = 2'd3;

   typedef struct packed {
      logic [2:0]                   opcode;
      logic signed [COORD_BITS-1:0] rect_x;
      logic signed [COORD_BITS-1:0] rect_y;
      logic [SIZE_BITS-1:0]         rect_w;
      logic [SIZE_BITS-1:0]         rect_h;
      logic [ID_BITS-1:0]           elem_id;
      logic                         last;
   } req_type;

   typedef struct packed {
      logic                found;
      logic                moved;
      logic [15:0]         best_id;
      logic [DIST_W-1:0]   best_distance;
      logic                done_res;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLAMP,
      ST_DIFF,
      ST_SQUARE,
      ST_SQRT_GO,
      ST_SQRT_WAIT,
      ST_SCORE,
      ST_FINISH
   } state_type;

endpackage

// ===== src/directional_focus_select.sv =====
// Top level of directional_focus_select: controller, scoring datapath,
// config registers. Depends on dfs_pkg and dfs_sqrt.
//
//  channel  ports                            role
//  req      req_valid/req_ready/req_data     opcode and rectangle item in
//  rsp      rsp_valid/rsp_ready/rsp_data     one result per finished search
//  csr      psel/penable/pwrite/paddr/...    viewport registers, APB style
//
// A set-focus item or an unused opcode stays in idle; a candidate outside
// the viewport passes clamp and finish; one outside the search half-plane
// or too far off axis adds diff and score; any other candidate adds square
// and the bit-serial square root (one root bit a cycle, 27 bits). One item
// is at work at a time. Reset is synchronous; a result waits in its output
// register and stalls only the last item of the next search.
module directional_focus_select (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  dfs_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output dfs_pkg::rsp_type                    rsp_data,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [dfs_pkg::ADDR_W-1:0]          paddr,
   input  logic [31:0]                         pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready
);
   localparam int EW = dfs_pkg::EDGE_W;
   localparam int DW = dfs_pkg::DIFF_W;
   localparam int CB = dfs_pkg::COORD_BITS;
   localparam int SB = dfs_pkg::SIZE_BITS;

   // configuration
   logic signed [CB-1:0] view_x_ff, view_y_ff;
   logic [SB-1:0]        view_w_ff, view_h_ff;
   logic                 csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         view_x_ff <= '0;
         view_y_ff <= '0;
         view_w_ff <= '0;
         view_h_ff <= '0;
      end else if (csr_wr) begin
         unique case (paddr[3:2])
            dfs_pkg::REG_VIEW_X: view_x_ff <= pwdata[CB-1:0];
            dfs_pkg::REG_VIEW_Y: view_y_ff <= pwdata[CB-1:0];
            dfs_pkg::REG_VIEW_W: view_w_ff <= pwdata[SB-1:0];
            dfs_pkg::REG_VIEW_H: view_h_ff <= pwdata[SB-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         dfs_pkg::REG_VIEW_X: prdata = 32'({16'b0, view_x_ff});
         dfs_pkg::REG_VIEW_Y: prdata = 32'({16'b0, view_y_ff});
         dfs_pkg::REG_VIEW_W: prdata = 32'(view_w_ff);
         dfs_pkg::REG_VIEW_H: prdata = 32'(view_h_ff);
         default:             prdata = '0;
      endcase
   end

   // state
   dfs_pkg::state_type   state_ff, state_in;
   dfs_pkg::req_type     item_ff;
   logic signed [CB-1:0] foc_x_ff, foc_y_ff;
   logic [SB-1:0]        foc_w_ff, foc_h_ff;
   logic [dfs_pkg::ID_BITS-1:0] foc_id_ff;
   logic                 has_focus_ff;
   logic signed [EW-1:0] fp_x_ff, fp_y_ff;
   logic [dfs_pkg::DIST_W-1:0]  best_score_ff;
   logic signed [CB-1:0] best_x_ff, best_y_ff;
   logic [SB-1:0]        best_w_ff, best_h_ff;
   logic [dfs_pkg::ID_BITS-1:0] best_id_ff;
   logic                 best_valid_ff;
   logic [DW-1:0]        dx_ff, dy_ff, disp_ff;
   logic                 plane_ff, reject_ff;
   logic [dfs_pkg::SQ_W-1:0] sqx_ff, sqy_ff;
   logic                 rsp_valid_ff;
   dfs_pkg::rsp_type     rsp_ff;

   // control outputs of the state machine
   logic take_item, do_clamp, do_diff, do_square, sqrt_go, do_score, do_finish;
   logic out_free;
   logic sqrt_done;
   logic [dfs_pkg::ROOT_W-1:0] root;

   assign out_free = !rsp_valid_ff || rsp_ready;

   // edges of item, focus and viewport
   logic signed [EW-1:0] px, py, prt, pbt, fx, fy, frt, fbt, vx, vy, vrt, vbt;
   logic                 p_ok, f_ok, v_ok, vert;
   assign px  = EW'(item_ff.rect_x);
   assign py  = EW'(item_ff.rect_y);
   assign prt = px + signed'(EW'(item_ff.rect_w)) - EW'(1);
   assign pbt = py + signed'(EW'(item_ff.rect_h)) - EW'(1);
   assign fx  = EW'(foc_x_ff);
   assign fy  = EW'(foc_y_ff);
   assign frt = fx + signed'(EW'(foc_w_ff)) - EW'(1);
   assign fbt = fy + signed'(EW'(foc_h_ff)) - EW'(1);
   assign vx  = EW'(view_x_ff);
   assign vy  = EW'(view_y_ff);
   assign vrt = vx + signed'(EW'(view_w_ff)) - EW'(1);
   assign vbt = vy + signed'(EW'(view_h_ff)) - EW'(1);
   assign p_ok = (item_ff.rect_w != '0) && (item_ff.rect_h != '0);
   assign f_ok = (foc_w_ff != '0) && (foc_h_ff != '0);
   assign v_ok = (view_w_ff != '0) && (view_h_ff != '0);
   assign vert = (item_ff.opcode == dfs_pkg::OP_UP) || (item_ff.opcode == dfs_pkg::OP_DOWN);

   logic cand_meets, focus_meets;
   assign cand_meets  = p_ok && v_ok && vx <= prt && px <= vrt && vy <= pbt && py <= vbt;
   assign focus_meets = f_ok && v_ok && vx <= frt && fx <= vrt && vy <= fbt && fy <= vbt;

   // clamp of the focus point
   logic signed [EW-1:0] fp_x_cl, fp_y_cl;
   always_comb begin
      fp_x_cl = fp_x_ff;
      fp_y_cl = fp_y_ff;
      if (vert) begin
         if (fp_x_ff < fx)       fp_x_cl = fx;
         else if (fp_x_ff > frt) fp_x_cl = frt;
         fp_y_cl = (item_ff.opcode == dfs_pkg::OP_UP) ? fy : fbt;
      end else begin
         fp_x_cl = (item_ff.opcode == dfs_pkg::OP_LEFT) ? fx : frt;
         if (fp_y_ff < fy)       fp_y_cl = fy;
         else if (fp_y_ff > fbt) fp_y_cl = fbt;
      end
   end

   // half-plane test, gaps and off-axis displacement
   logic                 outside, plane, far_off;
   logic signed [EW-1:0] dx_s, dy_s, disp_s, pl, pr, fl, fr;
   logic [SB-2:0]        half;
   always_comb begin
      outside = ((item_ff.opcode == dfs_pkg::OP_UP)    && pbt > fp_y_ff) ||
                ((item_ff.opcode == dfs_pkg::OP_DOWN)  && py  < fp_y_ff) ||
                ((item_ff.opcode == dfs_pkg::OP_RIGHT) && px  < fp_x_ff) ||
                ((item_ff.opcode == dfs_pkg::OP_LEFT)  && prt > fp_x_ff);
      dx_s = '0;
      dy_s = '0;
      if (vert) begin
         if (fp_x_ff < px)       dx_s = px - fp_x_ff;
         else if (fp_x_ff > prt) dx_s = fp_x_ff - prt;
         dy_s = (item_ff.opcode == dfs_pkg::OP_UP) ? fp_y_ff - pbt : py - fp_y_ff;
      end else begin
         dx_s = (item_ff.opcode == dfs_pkg::OP_RIGHT) ? px - fp_x_ff : fp_x_ff - prt;
         if (fp_y_ff < py)       dy_s = py - fp_y_ff;
         else if (fp_y_ff > pbt) dy_s = fp_y_ff - pbt;
      end
      pl   = vert ? px  : py;
      pr   = vert ? prt : pbt;
      fl   = vert ? fx  : fy;
      fr   = vert ? frt : fbt;
      half = vert ? view_w_ff[SB-1:1] : view_h_ff[SB-1:1];
      plane = (pl == fl) || (pr > fl && pr < fr) || (pl > fl && pl < fr) ||
              (pl > fl && pr < fr) || (pl < fl && pr > fr);
      disp_s = '0;
      if (pl > fr) disp_s = pl - fr;
      if (pr < fl) disp_s = fl - pr;
      if (disp_s == '0) disp_s = EW'(1);
      if (plane) disp_s = '0;
      far_off = !plane && focus_meets && (disp_s > signed'(EW'(half)));
   end

   // final score
   logic [dfs_pkg::LIN_W-1:0] lin;
   logic [dfs_pkg::SC_W-1:0]  total;
   logic [dfs_pkg::DIST_W-1:0] cand_dist;
   always_comb begin
      if (plane_ff)
         lin = vert ? dfs_pkg::LIN_W'(dy_ff) : dfs_pkg::LIN_W'(dx_ff);
      else
         lin = dfs_pkg::LIN_W'(dx_ff) + dfs_pkg::LIN_W'(dy_ff)
             + dfs_pkg::LIN_W'({disp_ff, 1'b0});
      total = (dfs_pkg::SC_W'(lin) << dfs_pkg::FRAC_BITS)
            + (plane_ff ? '0 : dfs_pkg::SC_W'(root));
      if (reject_ff || total > dfs_pkg::SC_W'(dfs_pkg::MAX_DIST))
         cand_dist = dfs_pkg::MAX_DIST;
      else
         cand_dist = total[dfs_pkg::DIST_W-1:0];
   end

   logic moved;
   assign moved = best_valid_ff && (!has_focus_ff || best_id_ff != foc_id_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dfs_pkg::ST_IDLE:
            if (req_valid && req_data.opcode < dfs_pkg::OP_FOCUS) state_in = dfs_pkg::ST_CLAMP;
         dfs_pkg::ST_CLAMP:
            state_in = cand_meets ? dfs_pkg::ST_DIFF : dfs_pkg::ST_FINISH;
         dfs_pkg::ST_DIFF:
            state_in = (outside || far_off) ? dfs_pkg::ST_SCORE : dfs_pkg::ST_SQUARE;
         dfs_pkg::ST_SQUARE:    state_in = dfs_pkg::ST_SQRT_GO;
         dfs_pkg::ST_SQRT_GO:   state_in = dfs_pkg::ST_SQRT_WAIT;
         dfs_pkg::ST_SQRT_WAIT: if (sqrt_done) state_in = dfs_pkg::ST_SCORE;
         dfs_pkg::ST_SCORE:     state_in = dfs_pkg::ST_FINISH;
         dfs_pkg::ST_FINISH:
            if (!item_ff.last || out_free) state_in = dfs_pkg::ST_IDLE;
         default: state_in = dfs_pkg::ST_IDLE;
      endcase
   end

   // state machine outputs
   always_comb begin
      req_ready = 1'b0;
      do_clamp  = 1'b0;
      do_diff   = 1'b0;
      do_square = 1'b0;
      sqrt_go   = 1'b0;
      do_score  = 1'b0;
      do_finish = 1'b0;
      unique case (state_ff)
         dfs_pkg::ST_IDLE:      req_ready = 1'b1;
         dfs_pkg::ST_CLAMP:     do_clamp  = cand_meets;
         dfs_pkg::ST_DIFF:      do_diff   = 1'b1;
         dfs_pkg::ST_SQUARE:    do_square = 1'b1;
         dfs_pkg::ST_SQRT_GO:   sqrt_go   = 1'b1;
         dfs_pkg::ST_SQRT_WAIT: ;
         dfs_pkg::ST_SCORE:     do_score  = 1'b1;
         dfs_pkg::ST_FINISH:    do_finish = item_ff.last && out_free;
         default: ;
      endcase
   end

   assign take_item = req_valid && req_ready;

   dfs_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_go),
      .radicand (dfs_pkg::RAD_W'(sqx_ff) + dfs_pkg::RAD_W'(sqy_ff)),
      .done     (sqrt_done),
      .root     (root)
   );

   // datapath registers without reset
   always_ff @(posedge clock) begin
      if (take_item) item_ff <= req_data;
      if (do_diff) begin
         dx_ff     <= DW'(dx_s);
         dy_ff     <= DW'(dy_s);
         disp_ff   <= DW'(disp_s);
         plane_ff  <= plane;
         reject_ff <= outside || far_off;
      end
      if (do_square) begin
         sqx_ff <= dfs_pkg::SQ_W'(dx_ff) * dfs_pkg::SQ_W'(dx_ff);
         sqy_ff <= dfs_pkg::SQ_W'(dy_ff) * dfs_pkg::SQ_W'(dy_ff);
      end
   end

   // architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= dfs_pkg::ST_IDLE;
         has_focus_ff  <= 1'b0;
         foc_x_ff      <= '0;
         foc_y_ff      <= '0;
         foc_w_ff      <= SB'(1);
         foc_h_ff      <= SB'(1);
         foc_id_ff     <= '0;
         fp_x_ff       <= '0;
         fp_y_ff       <= '0;
         best_score_ff <= dfs_pkg::MAX_DIST;
         best_x_ff     <= '0;
         best_y_ff     <= '0;
         best_w_ff     <= '0;
         best_h_ff     <= '0;
         best_id_ff    <= '0;
         best_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (do_finish)
            rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && rsp_ready)
            rsp_valid_ff <= 1'b0;
         if (take_item && req_data.opcode == dfs_pkg::OP_FOCUS) begin
            foc_x_ff     <= req_data.rect_x;
            foc_y_ff     <= req_data.rect_y;
            foc_w_ff     <= req_data.rect_w;
            foc_h_ff     <= req_data.rect_h;
            foc_id_ff    <= req_data.elem_id;
            has_focus_ff <= 1'b1;
            fp_x_ff      <= EW'(req_data.rect_x);
            fp_y_ff      <= EW'(req_data.rect_y);
         end
         if (do_clamp) begin
            fp_x_ff <= fp_x_cl;
            fp_y_ff <= fp_y_cl;
         end
         if (do_score && best_score_ff > cand_dist) begin
            best_score_ff <= cand_dist;
            best_x_ff     <= item_ff.rect_x;
            best_y_ff     <= item_ff.rect_y;
            best_w_ff     <= item_ff.rect_w;
            best_h_ff     <= item_ff.rect_h;
            best_id_ff    <= item_ff.elem_id;
            best_valid_ff <= 1'b1;
         end
         if (do_finish) begin
            if (moved) begin
               foc_x_ff     <= best_x_ff;
               foc_y_ff     <= best_y_ff;
               foc_w_ff     <= best_w_ff;
               foc_h_ff     <= best_h_ff;
               foc_id_ff    <= best_id_ff;
               has_focus_ff <= 1'b1;
            end
            // clear the running minimum for the next search
            best_score_ff <= dfs_pkg::MAX_DIST;
            best_x_ff     <= '0;
            best_y_ff     <= '0;
            best_w_ff     <= '0;
            best_h_ff     <= '0;
            best_id_ff    <= '0;
            best_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_finish) begin
         rsp_ff.found         <= best_valid_ff;
         rsp_ff.moved         <= moved;
         rsp_ff.best_id       <= best_valid_ff ? 16'(best_id_ff) : '0;
         rsp_ff.best_distance <= best_score_ff;
         rsp_ff.done_res      <= 1'b1;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule

// ===== src/dfs_sqrt.sv =====
// Bit-serial fixed-point square root: one root bit per cycle.
// Depends on dfs_pkg for the radicand and root widths.
module dfs_sqrt (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [dfs_pkg::RAD_W-1:0]      radicand,
   output logic                           done,
   output logic [dfs_pkg::ROOT_W-1:0]     root
);
   localparam int SH_W  = dfs_pkg::RAD_W + 2 * dfs_pkg::FRAC_BITS;
   localparam int REM_W = dfs_pkg::ROOT_W + 3;
   localparam int CNT_W = $clog2(dfs_pkg::ROOT_W + 1);

   logic [SH_W-1:0]               rad_ff, rad_in;
   logic [REM_W-1:0]              rem_ff, rem_in;
   logic [dfs_pkg::ROOT_W-1:0]    root_ff, root_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [REM_W-1:0]              rem_sh;
   logic [REM_W-1:0]              trial;

   assign rem_sh = {rem_ff[REM_W-3:0], rad_ff[SH_W-1 -: 2]};
   assign trial  = {1'b0, root_ff, 2'b01};

   always_comb begin
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rad_in  = {radicand, {(2 * dfs_pkg::FRAC_BITS){1'b0}}};
         rem_in  = '0;
         root_in = '0;
         cnt_in  = CNT_W'(dfs_pkg::ROOT_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in = {rad_ff[SH_W-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[dfs_pkg::ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[dfs_pkg::ROOT_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign root = root_ff;
endmodule

// ===== tb/directional_focus_select_tb.sv =====
// Self-checking testbench for directional_focus_select: drives opcode and
// rectangle items, predicts each search result, compares. Depends on dfs_pkg.
`timescale 1ns / 100ps

module directional_focus_select_tb;

   localparam longint MAXD = 64'd1000000 << dfs_pkg::FRAC_BITS;
   localparam int CYCLE_LIMIT = 2000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   dfs_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   dfs_pkg::rsp_type rsp_data;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [dfs_pkg::ADDR_W-1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   directional_focus_select dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #6 clock = ~clock;

   dfs_pkg::req_type pending_items[$];
   dfs_pkg::rsp_type expected_results[$];
   int error_count = 0;
   int searches_checked = 0;
   int items_sent = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int cycle_count = 0;
   logic req_took = 1'b0;

   // predictor state
   longint vx, vy, vw, vh;
   bit has_focus;
   longint fx, fy, fw, fh;
   longint focus_id;
   longint fpx, fpy;
   longint best_score;
   longint bx, by, bw, bh;
   longint best_id;
   bit best_valid;

   task automatic report(input string what, input longint got, input longint want);
      $display("MISMATCH %s: got %0d expected %0d", what, got, want);
      error_count++;
   endtask

   function automatic bit overlaps(longint ax, longint ay, longint aw, longint ah,
                                   longint cx, longint cy, longint cw, longint ch);
      if (aw <= 0 || ah <= 0 || cw <= 0 || ch <= 0) return 1'b0;
      return ax <= cx + cw - 1 && cx <= ax + aw - 1 &&
             ay <= cy + ch - 1 && cy <= ay + ah - 1;
   endfunction

   // floor(sqrt(s * 2^(2*FRAC_BITS)))
   function automatic longint root_fixed(longint unsigned s);
      longint unsigned n, res, bitv;
      n = s << (2 * dfs_pkg::FRAC_BITS);
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return longint'(res);
   endfunction

   function automatic longint nav_distance(int dir, longint px, longint py,
                                           longint pw, longint ph);
      longint dx, dy, disp, e, pr, pb, fr, fb, pl, pr2, fl, fr2, half;
      bit vert;
      dx = 0; dy = 0; disp = 0;
      vert = dir <= 1;
      pr = px + pw - 1; pb = py + ph - 1;
      fr = fx + fw - 1; fb = fy + fh - 1;
      // pull the focus point onto the focused rectangle's leading edge
      if (vert) begin
         if (fpx < fx) fpx = fx;
         else if (fpx > fr) fpx = fr;
         fpy = (dir == dfs_pkg::OP_UP) ? fy : fb;
      end else begin
         fpx = (dir == dfs_pkg::OP_LEFT) ? fx : fr;
         if (fpy < fy) fpy = fy;
         else if (fpy > fb) fpy = fb;
      end
      if ((dir == dfs_pkg::OP_UP && pb > fpy) || (dir == dfs_pkg::OP_DOWN && py < fpy) ||
          (dir == dfs_pkg::OP_RIGHT && px < fpx) || (dir == dfs_pkg::OP_LEFT && pr > fpx))
         return MAXD;
      if (vert) begin
         if (fpx < px) dx = px - fpx;
         else if (fpx > pr) dx = fpx - pr;
         dy = (dir == dfs_pkg::OP_UP) ? fpy - pb : py - fpy;
      end else begin
         dx = (dir == dfs_pkg::OP_RIGHT) ? px - fpx : fpx - pr;
         if (fpy < py) dy = py - fpy;
         else if (fpy > pb) dy = fpy - pb;
      end
      e = root_fixed(dx * dx + dy * dy);
      pl = vert ? px : py;  pr2 = vert ? pr : pb;
      fl = vert ? fx : fy;  fr2 = vert ? fr : fb;
      half = (vert ? vw : vh) / 2;
      if (pl == fl || (pr2 > fl && pr2 < fr2) || (pl > fl && pl < fr2) ||
          (pl > fl && pr2 < fr2) || (pl < fl && pr2 > fr2)) begin
         e = 0;
         if (vert) dx = 0; else dy = 0;
      end else begin
         if (pl > fr2) disp = pl - fr2;
         if (pr2 < fl) disp = fl - pr2;
         if (disp == 0) disp = 1;
         if (overlaps(vx, vy, vw, vh, fx, fy, fw, fh) && disp > half) return MAXD;
      end
      e += (dx + dy + 2 * disp) << dfs_pkg::FRAC_BITS;
      return (e > MAXD) ? MAXD : e;
   endfunction

   function automatic void clear_best();
      best_score = MAXD;
      bx = 0; by = 0; bw = 0; bh = 0;
      best_id = 0;
      best_valid = 1'b0;
   endfunction

   function automatic void predict_search(dfs_pkg::req_type it);
      longint rx, ry, rw, rh, d;
      bit mv;
      dfs_pkg::rsp_type r;
      rx = longint'(it.rect_x);
      ry = longint'(it.rect_y);
      rw = longint'(it.rect_w);
      rh = longint'(it.rect_h);
      if (it.opcode == dfs_pkg::OP_FOCUS) begin
         fx = rx; fy = ry; fw = rw; fh = rh;
         focus_id = longint'(it.elem_id);
         has_focus = 1'b1;
         fpx = rx; fpy = ry;
         return;
      end
      if (it.opcode > dfs_pkg::OP_FOCUS) return;
      if (overlaps(vx, vy, vw, vh, rx, ry, rw, rh)) begin
         d = nav_distance(int'(it.opcode), rx, ry, rw, rh);
         if (best_score > d) begin
            best_score = d;
            bx = rx; by = ry; bw = rw; bh = rh;
            best_id = longint'(it.elem_id);
            best_valid = 1'b1;
         end
      end
      if (!it.last) return;
      mv = best_valid && (!has_focus || best_id != focus_id);
      r.found = best_valid;
      r.moved = mv;
      r.best_id = best_valid ? 16'(best_id) : 16'd0;
      r.best_distance = dfs_pkg::DIST_W'(best_score);
      r.done_res = 1'b1;
      expected_results.push_back(r);
      if (mv) begin
         fx = bx; fy = by; fw = bw; fh = bh;
         focus_id = best_id;
         has_focus = 1'b1;
      end
      clear_best();
   endfunction

   // acceptance, prediction and checking
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      req_took <= req_valid && req_ready;
      if (!reset && req_valid && req_ready) predict_search(req_data);
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            report("unexpected result", 1, 0);
         end else begin
            dfs_pkg::rsp_type w;
            w = expected_results.pop_front();
            if (rsp_data.found !== w.found) report("found", rsp_data.found, w.found);
            if (rsp_data.moved !== w.moved) report("moved", rsp_data.moved, w.moved);
            if (rsp_data.best_id !== w.best_id)
               report("best_id", rsp_data.best_id, w.best_id);
            if (rsp_data.best_distance !== w.best_distance)
               report("best_distance", rsp_data.best_distance, w.best_distance);
            if (rsp_data.done_res !== w.done_res)
               report("done_res", rsp_data.done_res, w.done_res);
            searches_checked++;
         end
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // driver: hold an item until accepted, then advance
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && !req_took)) begin
         if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_data <= pending_items.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] value);
      @(negedge clock);
      psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
      paddr = dfs_pkg::ADDR_W'({idx, 2'b00}); pwdata = value;
      @(negedge clock);
      penable = 1'b1;
      @(negedge clock);
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
      case (idx)
         dfs_pkg::REG_VIEW_X: vx = longint'($signed(value[15:0]));
         dfs_pkg::REG_VIEW_Y: vy = longint'($signed(value[15:0]));
         dfs_pkg::REG_VIEW_W: vw = longint'(value[14:0]);
         dfs_pkg::REG_VIEW_H: vh = longint'(value[14:0]);
         default: ;
      endcase
   endtask

   task automatic set_view(input int x, input int y, input int w, input int h);
      csr_write(dfs_pkg::REG_VIEW_X, 32'(x));
      csr_write(dfs_pkg::REG_VIEW_Y, 32'(y));
      csr_write(dfs_pkg::REG_VIEW_W, 32'(w));
      csr_write(dfs_pkg::REG_VIEW_H, 32'(h));
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_items.size() != 0 || req_valid || expected_results.size() != 0);
      // a candidate that scores but yields no result may still be in flight
      repeat (60) @(negedge clock);
   endtask

   task automatic add_item(input logic [2:0] op, input int x, input int y,
                           input int w, input int h, input int id, input bit lst);
      dfs_pkg::req_type it;
      it.opcode = op;
      it.rect_x = 16'(x);
      it.rect_y = 16'(y);
      it.rect_w = 15'(w);
      it.rect_h = 15'(h);
      it.elem_id = 16'(id);
      it.last = lst;
      pending_items.push_back(it);
      items_sent++;
   endtask

   task automatic add_random_search(input int cx, input int cy, input int spread);
      int n, k, sz;
      n = $urandom_range(1, 7);
      if ($urandom_range(0, 99) < 40)
         add_item(dfs_pkg::OP_FOCUS, cx + $urandom_range(0, 2 * spread) - spread,
                  cy + $urandom_range(0, 2 * spread) - spread,
                  $urandom_range(0, 60), $urandom_range(0, 60),
                  $urandom_range(0, 15), 1'($urandom_range(0, 1)));
      for (k = 0; k < n; k++) begin
         if ($urandom_range(0, 99) < 8) begin
            // noise: full-range fields, unused opcodes included
            add_item(3'($urandom_range(0, 7)), $urandom, $urandom, $urandom, $urandom,
                     $urandom, k == n - 1);
         end else begin
            sz = ($urandom_range(0, 99) < 5) ? 32767 : 80;
            add_item(3'($urandom_range(0, 3)), cx + $urandom_range(0, 2 * spread) - spread,
                     cy + $urandom_range(0, 2 * spread) - spread,
                     $urandom_range(0, sz), $urandom_range(0, sz),
                     ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 15),
                     k == n - 1);
         end
      end
   endtask

   initial begin
      int ph, vxi, vyi, vwi, vhi, target;
      vx = 0; vy = 0; vw = 0; vh = 0;
      has_focus = 1'b0;
      fx = 0; fy = 0; fw = 1; fh = 1;
      focus_id = 0; fpx = 0; fpy = 0;
      clear_best();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty viewport: nothing can be scored
      add_item(dfs_pkg::OP_UP, 0, 0, 5, 5, 9, 1'b1);
      add_item(dfs_pkg::OP_RIGHT, 10, 0, 5, 5, 9, 1'b1);
      wait_drained();

      set_view(0, 0, 640, 480);
      // no focus yet: any winner moves
      add_item(dfs_pkg::OP_DOWN, 100, 300, 20, 20, 7, 1'b1);
      add_item(dfs_pkg::OP_FOCUS, 200, 200, 40, 20, 1, 1'b1);
      add_item(dfs_pkg::OP_UP, 200, 100, 40, 20, 2, 1'b0);
      add_item(dfs_pkg::OP_UP, 210, 50, 10, 10, 3, 1'b0);
      add_item(dfs_pkg::OP_UP, 600, 100, 10, 10, 4, 1'b0);
      add_item(dfs_pkg::OP_UP, 200, 300, 10, 10, 5, 1'b0);
      add_item(dfs_pkg::OP_UP, 200, 100, 0, 20, 6, 1'b1);
      add_item(dfs_pkg::OP_DOWN, 250, 300, 30, 30, 8, 1'b0);
      add_item(dfs_pkg::OP_DOWN, 2000, 300, 30, 30, 9, 1'b1);
      add_item(dfs_pkg::OP_LEFT, 50, 200, 20, 20, 10, 1'b0);
      add_item(dfs_pkg::OP_RIGHT, 400, 210, 20, 20, 11, 1'b1);
      add_item(dfs_pkg::OP_RIGHT, 450, 400, 20, 20, 12, 1'b0);
      add_item(dfs_pkg::OP_LEFT, 10, 190, 20, 20, 13, 1'b1);
      add_item(3'd5, 1, 1, 1, 1, 1, 1'b1);
      add_item(3'd6, -1, -1, 32767, 32767, 65535, 1'b1);
      add_item(3'd7, -32768, 32767, 0, 0, 0, 1'b1);
      add_item(dfs_pkg::OP_FOCUS, -32768, -32768, 0, 0, 65535, 1'b1);
      add_item(dfs_pkg::OP_DOWN, 10, 10, 32767, 32767, 65535, 1'b1);
      add_item(dfs_pkg::OP_FOCUS, 32767, 32767, 32767, 32767, 20, 1'b0);
      add_item(dfs_pkg::OP_LEFT, 0, 0, 10, 10, 21, 1'b1);
      wait_drained();

      for (ph = 0; ph < 6; ph++) begin
         send_idle_pct = (ph < 2) ? 20 : (ph < 4) ? 45 : 0;
         recv_idle_pct = (ph < 2) ? 45 : (ph < 4) ? 20 : 0;
         case (ph)
            0: begin vxi = -32768; vyi = -32768; vwi = 32767; vhi = 32767; end
            1: begin vxi = 32767; vyi = 32767; vwi = 1; vhi = 1; end
            2: begin vxi = -200; vyi = -100; vwi = 300; vhi = 200; end
            3: begin vxi = $urandom; vyi = $urandom; vwi = $urandom_range(1, 2000);
                     vhi = $urandom_range(1, 2000); end
            4: begin vxi = 1000; vyi = -5000; vwi = 0; vhi = 32767; end
            default: begin vxi = 0; vyi = 0; vwi = 800; vhi = 600; end
         endcase
         set_view(vxi, vyi, vwi, vhi);
         target = items_sent + 180;
         while (items_sent < target)
            add_random_search(vxi + vwi / 2, vyi + vhi / 2,
                              (ph == 1) ? 40 : ($urandom_range(0, 3) == 0) ? 2000 : 300);
         wait_drained();
      end

      $display("covered %0d items and %0d checked searches over six viewport settings",
               items_sent, searches_checked);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches", error_count);
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
